>>> hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

>>> hw/rtl/gsvc_pkg.sv
// Types and constants of the goal-seek velocity controller.
`timescale 1ns / 1ps

package gsvc_pkg;

  localparam int MAG_W      = 32;
  localparam int MUL_W      = 64;
  localparam int SUB_W      = 36;
  localparam int D2_W       = 66;
  localparam int ROOT_W     = 33;
  localparam int REM_W      = 34;
  localparam int Q_W        = 31;
  localparam int CNT_W      = 6;
  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 31;
  localparam int CFG_ADDR_W = 3;

  localparam logic [30:0] SPEED_RESET  = 31'd3277;
  localparam logic [30:0] THRESH_RESET = 31'd1311;

  localparam logic REG_SPEED  = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  typedef enum logic [1:0] {
    MODE_READY   = 2'd0,
    MODE_MOVING  = 2'd1,
    MODE_INVALID = 2'd2,
    MODE_DONE    = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_ACC,
    S_SQRT,
    S_THR,
    S_MUL,
    S_LOAD,
    S_DIV,
    S_SGN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [MAG_W-1:0] mul_a;
    logic [MAG_W-1:0] mul_b;
    logic [SUB_W-1:0] sub_a;
    logic [SUB_W-1:0] sub_b;
  } alu_req_t;

endpackage

>>> hw/rtl/gsvc_alu.sv
// Shared arithmetic unit: registered 32x32 multiplier and a compare-subtract.
`timescale 1ns / 1ps

module gsvc_alu (
  input  logic                      clk,
  input  gsvc_pkg::alu_req_t        req,
  output logic [gsvc_pkg::MUL_W-1:0] prod_r,
  output logic [gsvc_pkg::SUB_W-1:0] diff,
  output logic                      ge
);
  import gsvc_pkg::*;

  logic [SUB_W:0] sub_full;

  always_ff @(posedge clk) begin
    prod_r <= {{(MUL_W-MAG_W){1'b0}}, req.mul_a} * {{(MUL_W-MAG_W){1'b0}}, req.mul_b};
  end

  assign sub_full = {1'b0, req.sub_a} - {1'b0, req.sub_b};
  assign diff     = sub_full[SUB_W-1:0];
  assign ge       = ~sub_full[SUB_W];

endmodule

>>> hw/rtl/goal_seek_velocity_controller_core.sv
// Top level of the goal-seek velocity controller.
`timescale 1ns / 1ps

// Each input word is either a control step (current and goal position, signed
// Q16.16) or a command that forces the mode. A control step in mode ready or
// moving that moves on passes through these steps: three squares
// through the shared multiplier, a 33-step bit-pair square root, a threshold
// compare, and per axis one multiply by speed plus a 31-step restoring division,
// all on one multiplier and one 36-bit compare-subtract unit. A step that reaches
// the goal, or has zero distance, ends after the threshold compare. A force
// command, or a step in mode invalid or done, goes straight to the output state.
// in_ready is high only between words; a finished result waits in the output
// register, so the next word may be accepted before it is taken. Every word
// yields exactly one result word. Registers at byte address 0 (speed) and 4
// (arrive threshold) should be written only while the block is idle.

module goal_seek_velocity_controller_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_command,
  input  logic signed [31:0]               in_current_x,
  input  logic signed [31:0]               in_current_y,
  input  logic signed [31:0]               in_current_z,
  input  logic signed [31:0]               in_goal_x,
  input  logic signed [31:0]               in_goal_y,
  input  logic signed [31:0]               in_goal_z,
  input  logic [1:0]                       in_new_mode,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [31:0]               out_vel_x,
  output logic signed [31:0]               out_vel_y,
  output logic signed [31:0]               out_vel_z,
  output logic [1:0]                       out_mode_now,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [gsvc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);
  import gsvc_pkg::*;

  state_t           state_r, state_nxt;
  mode_t            mode_r, mode_nxt;
  logic [30:0]      speed_r, thresh_r;
  logic [MAG_W-1:0] mag_r [3];
  logic [MAG_W-1:0] mag_nxt [3];
  logic [2:0]       neg_r, neg_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [D2_W-1:0]  d2_r, d2_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [Q_W-1:0]   div_r, div_nxt;
  logic [31:0]      vel_r [3];
  logic [31:0]      vel_nxt [3];
  logic             out_valid_r;
  logic [31:0]      out_vel_r [3];
  mode_t            out_mode_r;

  alu_req_t          alu_req;
  logic [MUL_W-1:0]  prod_r;
  logic [SUB_W-1:0]  diff;
  logic              ge;

  logic signed [31:0] cur_in [3];
  logic signed [31:0] goal_in [3];
  logic signed [32:0] dif [3];
  logic [SUB_W-1:0]   sq_cur;
  logic [REM_W-1:0]   dv_cur;
  logic               accept;
  logic               out_load;
  logic               active_mode;
  logic               cfg_wr;

  gsvc_alu u_alu (
    .clk    (clk),
    .req    (alu_req),
    .prod_r (prod_r),
    .diff   (diff),
    .ge     (ge)
  );

  assign cur_in[0]  = in_current_x;
  assign cur_in[1]  = in_current_y;
  assign cur_in[2]  = in_current_z;
  assign goal_in[0] = in_goal_x;
  assign goal_in[1] = in_goal_y;
  assign goal_in[2] = in_goal_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif[i] = {goal_in[i][31], goal_in[i]} - {cur_in[i][31], cur_in[i]};
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign active_mode = (mode_r == MODE_READY) || (mode_r == MODE_MOVING);
  assign sq_cur      = {rem_r, d2_r[D2_W-1 -: 2]};
  assign dv_cur      = {rem_r[ROOT_W-1:0], div_r[Q_W-1]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (!in_command && active_mode) ? S_SQ : S_OUT;
        end
      end
      S_SQ:   state_nxt = S_ACC;
      S_ACC:  state_nxt = (idx_r == 2'd2) ? S_SQRT : S_SQ;
      S_SQRT: state_nxt = (cnt_r == '0) ? S_THR : S_SQRT;
      S_THR:  state_nxt = (!ge || root_r == '0) ? S_OUT : S_MUL;
      S_MUL:  state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_DIV;
      S_DIV:  state_nxt = (cnt_r == '0) ? S_SGN : S_DIV;
      S_SGN:  state_nxt = (idx_r == 2'd2) ? S_OUT : S_MUL;
      S_OUT:  state_nxt = (!out_valid_r || out_ready) ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    alu_req  = '0;
    mode_nxt = mode_r;
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    d2_nxt   = d2_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    div_nxt  = div_r;
    vel_nxt  = vel_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          for (int i = 0; i < 3; i++) begin
            vel_nxt[i] = '0;
            neg_nxt[i] = dif[i][32];
            mag_nxt[i] = dif[i][32] ? 32'(-dif[i]) : dif[i][31:0];
          end
          idx_nxt = '0;
          d2_nxt  = '0;
          if (in_command) begin
            mode_nxt = mode_t'(in_new_mode);
          end
        end
      end
      S_SQ: begin
        alu_req.mul_a = mag_r[idx_r];
        alu_req.mul_b = mag_r[idx_r];
      end
      S_ACC: begin
        d2_nxt = d2_r + {{(D2_W-MUL_W){1'b0}}, prod_r};
        if (idx_r == 2'd2) begin
          idx_nxt  = '0;
          rem_nxt  = '0;
          root_nxt = '0;
          cnt_nxt  = CNT_W'(SQRT_STEPS - 1);
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      S_SQRT: begin
        alu_req.sub_a = sq_cur;
        alu_req.sub_b = {1'b0, root_r, 2'b01};
        rem_nxt  = ge ? diff[REM_W-1:0] : sq_cur[REM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], ge};
        d2_nxt   = {d2_r[D2_W-3:0], 2'b00};
        cnt_nxt  = cnt_r - 1'b1;
      end
      S_THR: begin
        alu_req.sub_a = {{(SUB_W-ROOT_W){1'b0}}, root_r};
        alu_req.sub_b = {{(SUB_W-31){1'b0}}, thresh_r};
        mode_nxt = ge ? MODE_MOVING : MODE_DONE;
      end
      S_MUL: begin
        alu_req.mul_a = mag_r[idx_r];
        alu_req.mul_b = {1'b0, speed_r};
      end
      S_LOAD: begin
        rem_nxt = {{(REM_W-MAG_W){1'b0}}, prod_r[2*Q_W:Q_W]};
        div_nxt = prod_r[Q_W-1:0];
        cnt_nxt = CNT_W'(DIV_STEPS - 1);
      end
      S_DIV: begin
        alu_req.sub_a = {{(SUB_W-REM_W){1'b0}}, dv_cur};
        alu_req.sub_b = {{(SUB_W-ROOT_W){1'b0}}, root_r};
        rem_nxt = ge ? {1'b0, diff[ROOT_W-1:0]} : {1'b0, dv_cur[ROOT_W-1:0]};
        div_nxt = {div_r[Q_W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
      end
      S_SGN: begin
        vel_nxt[idx_r] = neg_r[idx_r] ? -{1'b0, div_r} : {1'b0, div_r};
        if (idx_r != 2'd2) begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_DONE;
      speed_r     <= SPEED_RESET;
      thresh_r    <= THRESH_RESET;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr) begin
        unique case (cfg_paddr[2])
          REG_SPEED:  speed_r  <= cfg_pwdata[30:0];
          REG_THRESH: thresh_r <= cfg_pwdata[30:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    d2_r   <= d2_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    div_r  <= div_nxt;
    vel_r  <= vel_nxt;
    if (out_load) begin
      out_vel_r  <= vel_r;
      out_mode_r <= mode_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_vel_x    = out_vel_r[0];
  assign out_vel_y    = out_vel_r[1];
  assign out_vel_z    = out_vel_r[2];
  assign out_mode_now = out_mode_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_THRESH) ? {1'b0, thresh_r} : {1'b0, speed_r};

endmodule

>>> hw/rtl/gsvc_checker.sv
// Port-level checker for the goal-seek velocity controller, bound to the top.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gsvc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_vel_x,
  input logic [31:0] out_vel_y,
  input logic [31:0] out_vel_z,
  input logic [1:0]  out_mode_now
);
  import gsvc_pkg::*;

  `ASSERT_IMPL(a_still_zero_vel, clk, rst_n, out_valid && out_mode_now != MODE_MOVING, out_vel_x == 32'd0 && out_vel_y == 32'd0 && out_vel_z == 32'd0)
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_vel_x) && $stable(out_vel_y) && $stable(out_vel_z) && $stable(out_mode_now))

endmodule

bind goal_seek_velocity_controller_core gsvc_checker u_gsvc_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for the goal-seek velocity controller core.
`timescale 1ns / 1ps

module testbench;
  import gsvc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 160;
  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  typedef struct packed {
    logic              command;
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] cur_z;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] goal_z;
    mode_t             new_mode;
  } ctl_word_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    mode_t             mode_now;
  } vel_word_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_command;
  logic signed [31:0] in_current_x;
  logic signed [31:0] in_current_y;
  logic signed [31:0] in_current_z;
  logic signed [31:0] in_goal_x;
  logic signed [31:0] in_goal_y;
  logic signed [31:0] in_goal_z;
  logic [1:0] in_new_mode;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_vel_x;
  logic signed [31:0] out_vel_y;
  logic signed [31:0] out_vel_z;
  logic [1:0] out_mode_now;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  logic [30:0] speed_q;
  logic [30:0] thresh_q;
  mode_t nav_mode;
  vel_word_t expected_velocity[$];
  bit steady_flow;
  int fail_count;
  int unsigned cycle_count;
  int unsigned words_sent;
  int unsigned results_checked;
  int unsigned force_count;
  int unsigned moving_count;
  int unsigned arrival_count;
  int unsigned held_count;
  int unsigned reg_writes;

  goal_seek_velocity_controller_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_current_x (in_current_x),
    .in_current_y (in_current_y),
    .in_current_z (in_current_z),
    .in_goal_x    (in_goal_x),
    .in_goal_y    (in_goal_y),
    .in_goal_z    (in_goal_z),
    .in_new_mode  (in_new_mode),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_vel_x    (out_vel_x),
    .out_vel_y    (out_vel_y),
    .out_vel_z    (out_vel_z),
    .out_mode_now (out_mode_now),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [33:0] floor_root(input logic [67:0] sq);
    logic [33:0] root;
    logic [33:0] trial;
    int b;
    root = '0;
    for (b = 33; b >= 0; b--) begin
      trial = root | (34'd1 << b);
      if ({34'd0, trial} * {34'd0, trial} <= sq) root = trial;
    end
    return root;
  endfunction

  function automatic logic [31:0] axis_velocity(input logic signed [32:0] d,
                                                input logic [33:0] len);
    logic [32:0] mag;
    logic [63:0] q;
    mag = d[32] ? -d : d;
    q = ({31'd0, mag} * {33'd0, speed_q}) / {30'd0, len};
    if (d[32]) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return ~q[31:0] + 32'd1;
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic vel_word_t predict_velocity(input ctl_word_t w);
    vel_word_t r;
    logic signed [32:0] dx, dy, dz;
    logic [32:0] ax, ay, az;
    logic [67:0] sq;
    logic [33:0] len;
    r = '0;
    if (w.command) begin
      nav_mode = w.new_mode;
      force_count++;
    end else if (nav_mode == MODE_READY || nav_mode == MODE_MOVING) begin
      dx = $signed({w.goal_x[31], w.goal_x}) - $signed({w.cur_x[31], w.cur_x});
      dy = $signed({w.goal_y[31], w.goal_y}) - $signed({w.cur_y[31], w.cur_y});
      dz = $signed({w.goal_z[31], w.goal_z}) - $signed({w.cur_z[31], w.cur_z});
      ax = dx[32] ? -dx : dx;
      ay = dy[32] ? -dy : dy;
      az = dz[32] ? -dz : dz;
      sq = {35'd0, ax} * {35'd0, ax} + {35'd0, ay} * {35'd0, ay}
         + {35'd0, az} * {35'd0, az};
      len = floor_root(sq);
      if (len < {3'd0, thresh_q}) begin
        nav_mode = MODE_DONE;
        arrival_count++;
      end else begin
        nav_mode = MODE_MOVING;
        moving_count++;
        if (len != 0) begin
          r.vel_x = axis_velocity(dx, len);
          r.vel_y = axis_velocity(dy, len);
          r.vel_z = axis_velocity(dz, len);
        end
      end
    end else begin
      held_count++;
    end
    r.mode_now = nav_mode;
    return r;
  endfunction

  function automatic ctl_word_t force_word(input mode_t m);
    ctl_word_t w;
    w.command = 1'b1;
    w.new_mode = m;
    w.cur_x = $urandom;
    w.cur_y = $urandom;
    w.cur_z = $urandom;
    w.goal_x = $urandom;
    w.goal_y = $urandom;
    w.goal_z = $urandom;
    return w;
  endfunction

  function automatic ctl_word_t step_word(input logic signed [31:0] cx, cy, cz, gx, gy, gz);
    ctl_word_t w;
    w.command = 1'b0;
    w.new_mode = mode_t'($urandom_range(0, 3));
    w.cur_x = cx;
    w.cur_y = cy;
    w.cur_z = cz;
    w.goal_x = gx;
    w.goal_y = gy;
    w.goal_z = gz;
    return w;
  endfunction

  function automatic logic signed [31:0] corner_value();
    case ($urandom_range(0, 5))
      0: return POS_MIN;
      1: return POS_MAX;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return 32'sd1;
      default: return ONE_Q16;
    endcase
  endfunction

  function automatic logic signed [31:0] near_point(input logic signed [31:0] pos);
    logic signed [31:0] off;
    off = $urandom_range(0, thresh_q >> $urandom_range(0, 2));
    if ($urandom_range(0, 1) == 1) off = -off;
    return pos + off;
  endfunction

  function automatic ctl_word_t random_step();
    ctl_word_t w;
    w = step_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3, 4, 5, 6: begin
        w.goal_x = near_point(w.cur_x);
        w.goal_y = near_point(w.cur_y);
        w.goal_z = near_point(w.cur_z);
      end
      7: begin
        w.goal_y = w.cur_y;
        w.goal_z = w.cur_z;
      end
      default: begin
        w = step_word(corner_value(), corner_value(), corner_value(),
                      corner_value(), corner_value(), corner_value());
      end
    endcase
    return w;
  endfunction

  task automatic send_word(input ctl_word_t w);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    repeat (gap) @(negedge clk);
    in_command = w.command;
    in_current_x = w.cur_x;
    in_current_y = w.cur_y;
    in_current_z = w.cur_z;
    in_goal_x = w.goal_x;
    in_goal_y = w.goal_y;
    in_goal_z = w.goal_z;
    in_new_mode = w.new_mode;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_velocity.push_back(predict_velocity(w));
    words_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic settle();
    while (expected_velocity.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = {reg_sel, 2'b00};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (reg_sel == REG_SPEED) speed_q = value[30:0];
    else thresh_q = value[30:0];
    reg_writes++;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic test_held_modes();
    send_word(random_step());
    send_word(force_word(MODE_INVALID));
    send_word(random_step());
    send_word(force_word(MODE_DONE));
    send_word(random_step());
  endtask

  task automatic test_mode_forces();
    send_word(force_word(MODE_READY));
    send_word(step_word(32'sd0, 32'sd0, 32'sd0, ONE_Q16, -ONE_Q16, ONE_Q16));
    send_word(force_word(MODE_MOVING));
    send_word(step_word(POS_MAX, 32'sd0, POS_MIN, 32'sd0, POS_MAX, 32'sd0));
  endtask

  task automatic test_direction_extremes();
    send_word(step_word(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX));
    send_word(step_word(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN));
    send_word(step_word(ONE_Q16, -ONE_Q16, 32'sd5, -ONE_Q16, ONE_Q16, 32'sd5));
  endtask

  task automatic test_arrival_edges();
    settle();
    write_reg(REG_SPEED, 32'hFFFF_FFFF);
    write_reg(REG_THRESH, 32'h8001_0000);
    send_word(step_word(32'sd0, 32'sd0, 32'sd0, ONE_Q16, 32'sd0, 32'sd0));
    send_word(step_word(32'sd0, 32'sd0, 32'sd0, -(ONE_Q16 - 1), 32'sd0, 32'sd0));
    send_word(force_word(MODE_READY));
    send_word(step_word(32'sd77, -32'sd3, POS_MIN, 32'sd77, -32'sd3, POS_MIN));
    settle();
    write_reg(REG_THRESH, 32'h0000_0000);
    send_word(force_word(MODE_READY));
    send_word(step_word(POS_MAX, 32'sd9, 32'sd0, POS_MAX, 32'sd9, 32'sd0));
    send_word(step_word(POS_MAX, 32'sd9, 32'sd0, POS_MIN, 32'sd9, 32'sd0));
  endtask

  task automatic test_random_sweep();
    int unsigned sent;
    int unsigned run;
    int phase;
    for (phase = 0; phase < 5; phase++) begin
      settle();
      case (phase)
        0: begin
          write_reg(REG_SPEED, 32'h7FFF_FFFF);
          write_reg(REG_THRESH, 32'h0000_0000);
        end
        1: begin
          write_reg(REG_SPEED, 32'h0000_0000);
          write_reg(REG_THRESH, 32'h7FFF_FFFF);
        end
        2: begin
          write_reg(REG_SPEED, $urandom);
          write_reg(REG_THRESH, $urandom);
        end
        default: begin
          write_reg(REG_SPEED, $urandom_range(0, 32'h0010_0000) | ($urandom << 31));
          write_reg(REG_THRESH, $urandom_range(0, 32'h0010_0000) | ($urandom << 31));
        end
      endcase
      sent = 0;
      while (sent < 100) begin
        steady_flow = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) send_word(force_word(mode_t'($urandom_range(0, 3))));
        else send_word(force_word($urandom_range(0, 1) ? MODE_READY : MODE_MOVING));
        run = $urandom_range(1, 8);
        repeat (run) send_word(random_step());
        sent += run + 1;
      end
      steady_flow = 1'b0;
    end
  endtask

  initial begin : result_drain
    int unsigned hold;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      hold = steady_flow ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        out_ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    vel_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_velocity.size() == 0) begin
        $error("result word with no expectation pending");
        fail_count++;
      end else begin
        want = expected_velocity.pop_front();
        results_checked++;
        if (out_vel_x !== want.vel_x) begin
          $error("vel_x: expected %0d, got %0d", $signed(want.vel_x), out_vel_x);
          fail_count++;
        end
        if (out_vel_y !== want.vel_y) begin
          $error("vel_y: expected %0d, got %0d", $signed(want.vel_y), out_vel_y);
          fail_count++;
        end
        if (out_vel_z !== want.vel_z) begin
          $error("vel_z: expected %0d, got %0d", $signed(want.vel_z), out_vel_z);
          fail_count++;
        end
        if (out_mode_now !== want.mode_now) begin
          $error("mode_now: expected %0d, got %0d", want.mode_now, out_mode_now);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = 1'b0;
    in_current_x = '0;
    in_current_y = '0;
    in_current_z = '0;
    in_goal_x = '0;
    in_goal_y = '0;
    in_goal_z = '0;
    in_new_mode = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    speed_q = SPEED_RESET;
    thresh_q = THRESH_RESET;
    nav_mode = MODE_DONE;
    steady_flow = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    words_sent = 0;
    results_checked = 0;
    force_count = 0;
    moving_count = 0;
    arrival_count = 0;
    held_count = 0;
    reg_writes = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_held_modes();
    test_mode_forces();
    test_direction_extremes();
    test_arrival_edges();
    test_random_sweep();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words, checked %0d results, %0d register writes.",
             words_sent, results_checked, reg_writes);
    $display("Mode forces %0d, steps toward goal %0d, arrivals %0d, held steps %0d.",
             force_count, moving_count, arrival_count, held_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
